>>> rtl/vector_shape_record_parser_assert.svh
// Assertion macros for the shape record parser checker.
`ifndef VECTOR_SHAPE_RECORD_PARSER_ASSERT_SVH
`define VECTOR_SHAPE_RECORD_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define VSRP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vsrp check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define VSRP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vsrp check failed");

`endif

>>> rtl/vsrp_pkg.sv
package vsrp_pkg;

  localparam int unsigned NUM_WORDS   = 7;
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);
  localparam logic [31:0] LIMIT_RESET = 32'd1000000;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_MAGIC = 3'd1;
  localparam logic [2:0] ST_COUNT = 3'd2;
  localparam logic [2:0] ST_NOTAG = 3'd3;
  localparam logic [2:0] ST_TRUNC = 3'd4;
  localparam logic [2:0] ST_TYPE  = 3'd5;
  localparam logic [2:0] ST_TRAIL = 3'd6;

  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_LINE    = 3'd1;
  localparam logic [2:0] KIND_RECT    = 3'd2;
  localparam logic [2:0] KIND_ELLIPSE = 3'd3;
  localparam logic [2:0] KIND_CIRCLE  = 3'd4;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE  = 8'h31;

  typedef enum logic [1:0] {
    PH_MAGIC,
    PH_COUNT,
    PH_TAG,
    PH_BODY
  } vsrp_phase_t;

  // Byte as queued by the front end, with its classification.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       tag_ok;   // type byte 1..4
    logic       fmt_ok;   // '0' or '1'
    logic       fmt_rot;  // '1'
  } vsrp_item_t;

  typedef struct packed {
    logic                        shape_valid;
    logic [2:0]                  kind;
    logic                        with_rot;
    logic [NUM_WORDS-1:0][31:0]  words;
    logic                        done;
    logic [2:0]                  status;
  } vsrp_result_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] v;
    unique case (idx)
      2'd0:    v = 8'h56;  // V
      2'd1:    v = 8'h45;  // E
      2'd2:    v = 8'h43;  // C
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] words_needed(input logic [2:0] kind, input logic rot);
    logic [2:0] n;
    unique case (kind)
      KIND_LINE:                n = 3'd6;
      KIND_RECT, KIND_ELLIPSE:  n = rot ? 3'd7 : 3'd6;
      default:                  n = 3'd5;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/vsrp_front.sv
module vsrp_front
  import vsrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       q_valid,
  output vsrp_item_t q_item,
  input  logic       q_pop
);

  vsrp_item_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;
  logic                push, pop;
  vsrp_item_t          item_in;

  assign in_stall = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_comb begin
    item_in.data    = in_data_byte;
    item_in.last    = in_last_byte;
    item_in.tag_ok  = (in_data_byte >= 8'd1) && (in_data_byte <= 8'd4);
    item_in.fmt_ok  = (in_data_byte == CH_ZERO) || (in_data_byte == CH_ONE);
    item_in.fmt_rot = (in_data_byte == CH_ONE);
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

>>> rtl/vsrp_back.sv
module vsrp_back
  import vsrp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  input  logic         q_valid,
  input  vsrp_item_t   q_item,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_stall,
  output vsrp_result_t res
);

  vsrp_phase_t                phase_r, phase_nxt;
  logic [4:0]                 pos_r, pos_nxt;
  logic                       rot_r, rot_nxt;
  logic [31:0]                count_r, count_nxt;
  logic [31:0]                left_r, left_nxt;
  logic [2:0]                 kind_r, kind_nxt;
  logic [NUM_WORDS-1:0][31:0] words_r, words_nxt;
  logic                       drop_r, drop_nxt;
  logic [31:0]                limit_r;
  logic                       out_valid_r;
  vsrp_result_t               res_r;

  logic                       step;
  logic [7:0]                 b;
  logic                       last;
  logic [4:0]                 pos_inc;
  logic [5:0]                 pos6;
  logic [31:0]                cnt_word;
  logic                       cnt_end;
  logic                       cnt_bad;
  logic [NUM_WORDS-1:0][31:0] words_mrg;
  logic                       body_end;
  logic [31:0]                left_dec;

  logic                       r_shape;
  logic                       r_done;
  logic [2:0]                 r_status;

  assign step    = q_valid && (!out_valid_r || !out_stall);
  assign q_pop   = step;
  assign b       = q_item.data;
  assign last    = q_item.last;
  assign pos_inc = pos_r + 5'd1;
  assign pos6    = {1'b0, pos_r} + 6'd1;
  assign cnt_end = (pos_r[1:0] == 2'd3);
  assign cnt_bad = (cnt_word > limit_r);
  assign left_dec = left_r - 32'd1;
  assign body_end = (pos6 >= {1'b0, words_needed(kind_r, rot_r), 2'b00});

  // Byte lanes land in place; the target is zero when written.
  always_comb begin
    cnt_word = count_r;
    cnt_word[{pos_r[1:0], 3'b000} +: 8] = b;
  end

  always_comb begin
    words_mrg = words_r;
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (pos_r[4:2] == 3'(w)) begin
        words_mrg[w][{pos_r[1:0], 3'b000} +: 8] = b;
      end
    end
  end

  // Result decision per byte.
  always_comb begin
    r_shape  = 1'b0;
    r_done   = 1'b0;
    r_status = ST_OK;
    if (step && !drop_r) begin
      unique case (phase_r)
        PH_COUNT: begin
          if (cnt_end) begin
            if (cnt_bad) begin
              r_done = 1'b1; r_status = ST_COUNT;
            end else if (last) begin
              r_done = 1'b1; r_status = (cnt_word == '0) ? ST_OK : ST_NOTAG;
            end
          end else if (last) begin
            r_done = 1'b1; r_status = ST_COUNT;
          end
        end
        PH_TAG: begin
          if (left_r == '0) begin
            r_done = 1'b1; r_status = ST_TRAIL;
          end else if (!q_item.tag_ok) begin
            r_done = 1'b1; r_status = ST_TYPE;
          end else if (last) begin
            r_done = 1'b1; r_status = ST_TRUNC;
          end
        end
        PH_BODY: begin
          if (body_end) begin
            r_shape = 1'b1;
            if (last) begin
              r_done = 1'b1; r_status = (left_dec == '0) ? ST_OK : ST_NOTAG;
            end
          end else if (last) begin
            r_done = 1'b1; r_status = ST_TRUNC;
          end
        end
        PH_MAGIC: begin
          if (pos_r < 5'd3) begin
            if (b != magic_byte(pos_r[1:0]) || last) begin
              r_done = 1'b1; r_status = ST_MAGIC;
            end
          end else if (!q_item.fmt_ok) begin
            r_done = 1'b1; r_status = ST_MAGIC;
          end else if (last) begin
            r_done = 1'b1; r_status = ST_COUNT;
          end
        end
        default: ;
      endcase
    end
  end

  // Next parse state.
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    rot_nxt   = rot_r;
    count_nxt = count_r;
    left_nxt  = left_r;
    kind_nxt  = kind_r;
    words_nxt = words_r;
    drop_nxt  = drop_r;
    if (step) begin
      if (drop_r || r_done) begin
        // back to the start of a buffer; word store is cleared at the next tag
        if (drop_r) begin
          drop_nxt = !last;
          if (last) drop_nxt = 1'b0;
        end else begin
          drop_nxt = !last;
        end
        if (!drop_r || last) begin
          phase_nxt = PH_MAGIC;
          pos_nxt   = '0;
          rot_nxt   = 1'b0;
          count_nxt = '0;
          left_nxt  = '0;
          kind_nxt  = KIND_NONE;
        end
      end else begin
        unique case (phase_r)
          PH_COUNT: begin
            count_nxt = cnt_word;
            if (cnt_end) begin
              left_nxt  = cnt_word;
              phase_nxt = PH_TAG;
              pos_nxt   = '0;
            end else begin
              pos_nxt = pos_inc;
            end
          end
          PH_TAG: begin
            kind_nxt  = b[2:0];
            words_nxt = '0;
            phase_nxt = PH_BODY;
            pos_nxt   = '0;
          end
          PH_BODY: begin
            words_nxt = words_mrg;
            if (body_end) begin
              left_nxt  = left_dec;
              phase_nxt = PH_TAG;
              pos_nxt   = '0;
              kind_nxt  = KIND_NONE;
            end else begin
              pos_nxt = pos_inc;
            end
          end
          PH_MAGIC: begin
            if (pos_r < 5'd3) begin
              pos_nxt = pos_inc;
            end else begin
              rot_nxt   = q_item.fmt_rot;
              phase_nxt = PH_COUNT;
              pos_nxt   = '0;
              count_nxt = '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MAGIC;
      pos_r       <= '0;
      rot_r       <= 1'b0;
      count_r     <= '0;
      left_r      <= '0;
      kind_r      <= KIND_NONE;
      drop_r      <= 1'b0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      rot_r   <= rot_nxt;
      count_r <= count_nxt;
      left_r  <= left_nxt;
      kind_r  <= kind_nxt;
      drop_r  <= drop_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (step) begin
        out_valid_r <= r_shape || r_done;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r <= '0;
    end else begin
      words_r <= words_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r.shape_valid <= r_shape;
      res_r.kind        <= r_shape ? kind_r : KIND_NONE;
      res_r.with_rot    <= r_shape && rot_r;
      res_r.words       <= r_shape ? words_mrg : '0;
      res_r.done        <= r_done;
      res_r.status      <= r_status;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

>>> rtl/vector_shape_record_parser.sv
// Vector shape record parser. Bytes of an encoded shape buffer enter on the
// in_ channel (last byte marked) and leave as one result per completed record
// or final status on the out_ channel. Sustained rate is one byte per clock
// while out_stall is low. With the queue ahead of it empty, an accepted byte
// goes into the four-entry input queue, from which the parse stage reads it
// and loads the output register. in_stall rises only when the queue is full,
// so a stalled output holds at most four more bytes. shape_limit is written
// through cfg_wr_en/cfg_wr_data and resets to 1000000; the user must write
// it only while the block is idle, which the block itself does not enforce.
module vector_shape_record_parser
  import vsrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_shape_valid,
  output logic [2:0]  out_kind,
  output logic        out_with_rotation,
  output logic [31:0] out_word_zero,
  output logic [31:0] out_word_one,
  output logic [31:0] out_word_two,
  output logic [31:0] out_word_three,
  output logic [31:0] out_word_four,
  output logic [31:0] out_word_five,
  output logic [31:0] out_word_six,
  output logic        out_done_res,
  output logic [2:0]  out_status
);

  logic         q_valid;
  logic         q_pop;
  vsrp_item_t   q_item;
  vsrp_result_t res;

  vsrp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  vsrp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .res         (res)
  );

  assign out_shape_valid   = res.shape_valid;
  assign out_kind          = res.kind;
  assign out_with_rotation = res.with_rot;
  assign out_word_zero     = res.words[0];
  assign out_word_one      = res.words[1];
  assign out_word_two      = res.words[2];
  assign out_word_three    = res.words[3];
  assign out_word_four     = res.words[4];
  assign out_word_five     = res.words[5];
  assign out_word_six      = res.words[6];
  assign out_done_res      = res.done;
  assign out_status        = res.status;

endmodule

>>> rtl/vsrp_checker.sv
`include "vector_shape_record_parser_assert.svh"

module vsrp_checker
  import vsrp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_shape_valid,
  input logic [2:0]  out_kind,
  input logic        out_with_rotation,
  input logic [31:0] out_word_zero,
  input logic        out_done_res,
  input logic [2:0]  out_status
);

  // A stalled transaction keeps its status and record.
  `VSRP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_word_zero) && $stable(out_shape_valid))

  // Every result carries a record or a final status.
  `VSRP_ASSERT_IMP(a_not_empty, out_valid, out_shape_valid || out_done_res)

  // A result without a record has a cleared payload.
  `VSRP_ASSERT_IMP(a_no_shape_zero, out_valid && !out_shape_valid, out_kind == KIND_NONE && !out_with_rotation && out_word_zero == '0)

  // A record always has a known type.
  `VSRP_ASSERT_IMP(a_kind_known, out_valid && out_shape_valid, out_kind == KIND_LINE || out_kind == KIND_RECT || out_kind == KIND_ELLIPSE || out_kind == KIND_CIRCLE)

  // Status is only reported with a final result.
  `VSRP_ASSERT_IMP(a_status_final, out_valid && !out_done_res, out_status == ST_OK)

endmodule

bind vector_shape_record_parser vsrp_checker u_vsrp_checker (.*);
